/* hdl/msrb_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// msrb_pkg: shared types and constants of the sprite row blitter
// field widths, shift register width and the scan status bundle
// ----------------------------------------------------------------------------
package msrb_pkg;

	localparam int COORD_W   = 11;  // signed screen coordinate of a sprite
	localparam int POS_W     = 12;  // coordinate after adding a column or row
	localparam int ROW_W     = 4;
	localparam int BITS_W    = 16;
	localparam int RWIDTH_W  = 5;
	localparam int COLOR_W   = 16;
	localparam int ADDR_W    = 32;
	localparam int LINE_SHIFT = 10; // bytes per screen line, as a shift
	localparam int PAT_W     = 32;  // pattern shift register, covers widest sprite
	localparam int CNT_W     = 6;   // column count, holds up to PAT_W

	typedef logic [CNT_W-1:0] col_cnt_t;

	typedef struct packed {
		logic busy;  // columns remain in the current row
		logic cand;  // current column is a set bit on screen
	} scan_st_t;

endpackage

/* hdl/msrb_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// msrb_if: channel interfaces of the sprite row blitter
// row channel in, pixel write channel out, valid/ready handshake
// ----------------------------------------------------------------------------
interface msrb_row_if;
	logic               valid;
	logic               ready;
	logic signed [10:0] sprite_x;
	logic signed [10:0] sprite_y;
	logic [3:0]         row_index;
	logic [15:0]        row_bits;
	logic [4:0]         row_width;
	logic               mirror;
	logic [15:0]        color;

	modport source (output valid, sprite_x, sprite_y, row_index, row_bits, row_width,
		mirror, color, input ready);
	modport sink (input valid, sprite_x, sprite_y, row_index, row_bits, row_width,
		mirror, color, output ready);
endinterface

interface msrb_pix_if;
	logic        valid;
	logic        ready;
	logic [31:0] pixel_address;
	logic [15:0] pixel_color;
	logic        last_of_row;

	modport source (output valid, pixel_address, pixel_color, last_of_row, input ready);
	modport sink (input valid, pixel_address, pixel_color, last_of_row, output ready);
endinterface

/* hdl/msrb_col_scan.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// msrb_col_scan: column serializer
// shifts the row pattern out one bit per column and tracks the screen column
// ----------------------------------------------------------------------------
module msrb_col_scan
	import msrb_pkg::*;
#(
	parameter int SCREEN_WIDTH = 320
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      load,
	input  logic                      adv,
	input  logic [BITS_W-1:0]         ld_bits,
	input  logic                      ld_mirror,
	input  col_cnt_t                  ld_width,
	input  logic signed [COORD_W-1:0] ld_x,
	output scan_st_t                  st
);

	logic [PAT_W-1:0]        pat_q;
	logic                    mirror_q;
	logic signed [POS_W-1:0] col_q;
	col_cnt_t                cnt_q;
	logic [PAT_W-1:0]        pat_ld;
	logic [CNT_W:0]          ld_shift;
	logic                    cur_bit;
	logic                    on_screen;

	// non-mirrored rows are aligned so column zero sits at the msb
	assign ld_shift = (CNT_W+1)'(PAT_W) - {1'b0, ld_width};
	assign pat_ld   = ld_mirror ? PAT_W'(ld_bits) : (PAT_W'(ld_bits) << ld_shift);

	assign cur_bit   = mirror_q ? pat_q[0] : pat_q[PAT_W-1];
	assign on_screen = !col_q[POS_W-1] && (col_q < POS_W'(SCREEN_WIDTH));

	assign st.busy = (cnt_q != '0);
	assign st.cand = st.busy && cur_bit && on_screen;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (load) begin
			cnt_q <= ld_width;
		end else if (adv) begin
			cnt_q <= cnt_q - col_cnt_t'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			pat_q    <= pat_ld;
			mirror_q <= ld_mirror;
			col_q    <= POS_W'(ld_x);
		end else if (adv) begin
			pat_q <= mirror_q ? (pat_q >> 1) : (pat_q << 1);
			col_q <= col_q + POS_W'(1);
		end
	end

endmodule

/* hdl/mono_sprite_row_blitter.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mono_sprite_row_blitter: one-bit sprite row to pixel write expander
// turns one sprite row into halfword frame buffer writes, leftmost first
// ----------------------------------------------------------------------------
// usage
//   rows    : one beat per sprite row (position, row index, pattern, width,
//             mirror flag, color); taken only while the blitter is idle
//   pixels  : one beat per visible set bit, address and color; last_of_row
//             marks the final write of a row; rows with nothing on screen
//             give no beat at all
//   cfg_we / cfg_wdata : writes frame_base, the frame buffer byte address;
//             write it only while no row is in flight
// timing
//   a row is accepted, the sprite column is added to the address, the
//   columns step through the pattern shift register and the held write
//   is released; a rejected row (row or line off screen, zero width) leaves
//   the blitter idle once accepted
//   the first write goes through the hold buffer and the output register and
//   leaves when the next set column or the row end is reached; then at most one per cycle
// reset
//   arst_n clears the sequencer and both write buffers, frame_base returns to 0xC8000000
// stall
//   a stalled pixels port freezes the column scan at a set column once its
//   one-entry hold buffer and the output register are full; nothing is dropped
// ----------------------------------------------------------------------------
module mono_sprite_row_blitter
	import msrb_pkg::*;
#(
	parameter int SCREEN_WIDTH     = 320,
	parameter int SCREEN_HEIGHT    = 240,
	parameter int MAX_SPRITE_WIDTH = 16,
	parameter int MAX_SPRITE_ROWS  = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic [ADDR_W-1:0] cfg_wdata,
	msrb_row_if.sink          rows,
	msrb_pix_if.source        pixels
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_PREP = 2'd1;
	localparam logic [1:0] ST_SCAN = 2'd2;

	localparam logic [ADDR_W-1:0] FRAME_BASE_RST = 32'hC800_0000;

	logic [1:0]              state_q;
	logic [ADDR_W-1:0]       frame_base_q;
	logic [ADDR_W-1:0]       addr_q;       // address of the current column
	logic signed [COORD_W-1:0] sx_q;
	logic [COLOR_W-1:0]      color_q;

	// one write held back until we know whether it is the last of its row
	logic                    hold_v_q;
	logic [ADDR_W-1:0]       hold_addr_q;

	// output register
	logic                    out_v_q;
	logic [ADDR_W-1:0]       out_addr_q;
	logic [COLOR_W-1:0]      out_color_q;
	logic                    out_last_q;

	logic                    accept;
	logic signed [POS_W-1:0] line;
	logic                    line_ok;
	logic                    row_ok;
	col_cnt_t                width_sat;
	logic                    go;
	logic [ADDR_W-1:0]       line_off;
	logic                    out_free;
	logic                    adv;
	logic                    push_mid;
	logic                    push_end;
	logic                    done;
	scan_st_t                scan_st;

	assign rows.ready = (state_q == ST_IDLE);
	assign accept     = rows.valid && rows.ready;

	// row screening: line on screen, row inside the sprite, nonzero width
	assign line      = POS_W'(rows.sprite_y) + POS_W'(rows.row_index);
	assign line_ok   = !line[POS_W-1] && (line < POS_W'(SCREEN_HEIGHT));
	assign row_ok    = (CNT_W'(rows.row_index) < CNT_W'(MAX_SPRITE_ROWS));
	assign width_sat = (CNT_W'(rows.row_width) > CNT_W'(MAX_SPRITE_WIDTH)) ?
		CNT_W'(MAX_SPRITE_WIDTH) : CNT_W'(rows.row_width);
	assign go        = line_ok && row_ok && (width_sat != '0);
	assign line_off  = ADDR_W'(line[POS_W-2:0]) << LINE_SHIFT;

	// scan moves on unless a second candidate would need a busy output
	assign out_free = !out_v_q || pixels.ready;
	assign adv      = (state_q == ST_SCAN) && scan_st.busy &&
		(!(scan_st.cand && hold_v_q) || out_free);
	assign push_mid = adv && scan_st.cand && hold_v_q;
	assign push_end = (state_q == ST_SCAN) && !scan_st.busy && hold_v_q && out_free;
	assign done     = (state_q == ST_SCAN) && !scan_st.busy && (!hold_v_q || out_free);

	msrb_col_scan #(
		.SCREEN_WIDTH (SCREEN_WIDTH)
	) u_scan (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (accept),
		.adv       (adv),
		.ld_bits   (rows.row_bits),
		.ld_mirror (rows.mirror),
		.ld_width  (width_sat),
		.ld_x      (rows.sprite_x),
		.st        (scan_st)
	);

	// frame base register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_base_q <= FRAME_BASE_RST;
		end else if (cfg_we) begin
			frame_base_q <= cfg_wdata;
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept && go) state_q <= ST_PREP;
				end
				ST_PREP: begin
					state_q <= ST_SCAN;
				end
				ST_SCAN: begin
					if (done) state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// address walk: line base, then the sprite column, then +2 per column
	always_ff @(posedge clk) begin
		if (accept) begin
			addr_q  <= frame_base_q + line_off;
			sx_q    <= rows.sprite_x;
			color_q <= rows.color;
		end else if (state_q == ST_PREP) begin
			addr_q <= addr_q + {{(ADDR_W-COORD_W-1){sx_q[COORD_W-1]}}, sx_q, 1'b0};
		end else if (adv) begin
			addr_q <= addr_q + ADDR_W'(2);
		end
	end

	// hold buffer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_v_q <= 1'b0;
		end else if (adv && scan_st.cand) begin
			hold_v_q <= 1'b1;
		end else if (push_end) begin
			hold_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && scan_st.cand) hold_addr_q <= addr_q;
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (push_mid || push_end) begin
			out_v_q <= 1'b1;
		end else if (pixels.ready) begin
			out_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (push_mid || push_end) begin
			out_addr_q  <= hold_addr_q;
			out_color_q <= color_q;
			out_last_q  <= push_end;
		end
	end

	assign pixels.valid         = out_v_q;
	assign pixels.pixel_address = out_addr_q;
	assign pixels.pixel_color   = out_color_q;
	assign pixels.last_of_row   = out_last_q;

endmodule

/* bench/mono_sprite_row_blitter_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mono_sprite_row_blitter_test: self-checking bench of the sprite row blitter
// drives sprite rows with random handshake gaps, predicts every pixel write
// in the bench and compares each write beat with the oldest prediction;
// walks frame_base through its reset value, 0xFFF80000, a random one and both extreme values
// ----------------------------------------------------------------------------
module mono_sprite_row_blitter_test
	import msrb_pkg::*;
();

	// screen geometry handed to the block, also used by the predictor
	localparam int SCR_W      = 320;
	localparam int SCR_H      = 240;
	localparam int SPR_W_MAX  = 16;
	localparam int SPR_ROWS   = 16;

	localparam logic [ADDR_W-1:0] FRAME_BASE_RESET = 32'hC800_0000;
	localparam int DRAIN_CYCLES = 40;      // covers a silent row of the widest sprite
	localparam int CYCLE_LIMIT  = 400_000; // far above the slowest legal run

	typedef struct packed {
		logic [COORD_W-1:0]  sx;
		logic [COORD_W-1:0]  sy;
		logic [ROW_W-1:0]    row;
		logic [BITS_W-1:0]   bits;
		logic [RWIDTH_W-1:0] width;
		logic                mirror;
		logic [COLOR_W-1:0]  color;
	} sprite_row_t;

	typedef struct packed {
		logic [ADDR_W-1:0]  addr;
		logic [COLOR_W-1:0] color;
		logic               last;
	} pixel_write_t;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [ADDR_W-1:0] cfg_wdata;

	msrb_row_if row_ch ();
	msrb_pix_if pix_ch ();

	mono_sprite_row_blitter #(
		.SCREEN_WIDTH     (SCR_W),
		.SCREEN_HEIGHT    (SCR_H),
		.MAX_SPRITE_WIDTH (SPR_W_MAX),
		.MAX_SPRITE_ROWS  (SPR_ROWS)
	) uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.rows      (row_ch),
		.pixels    (pix_ch)
	);

	// rows waiting to be sent, and pixel writes predicted but not yet seen
	sprite_row_t  rows_pending[$];
	pixel_write_t writes_due[$];

	// bench copy of the frame base register
	logic [ADDR_W-1:0] base_shadow;

	bit quiet;       // no idling on either side in the closing phase
	bit row_taken;   // row beat accepted at the last rising edge
	int send_gap;
	int stall_gap;
	int errors;
	int rows_sent;
	int rows_blank;
	int writes_seen;
	int bases_used;
	int cycles;
	sprite_row_t next_row;

	// 8 ns clock
	initial clk = 1'b0;
	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// watchdog
	always @(posedge clk) begin
		cycles++;
		if (cycles == CYCLE_LIMIT) begin
			$display("%0t ns: timeout with %0d writes still due", $time, writes_due.size());
			$display("mono_sprite_row_blitter_test failed");
			$finish;
		end
	end

	// expand one accepted row into the writes it should cause, leftmost first
	task automatic expand_row(input sprite_row_t r);
		int sx_i;
		int sy_i;
		int line;
		int wid;
		int col;
		int bit_no;
		pixel_write_t hits[$];
		pixel_write_t w;
		sx_i = $signed(r.sx);
		sy_i = $signed(r.sy);
		line = sy_i + int'(r.row);
		// oversized widths saturate, pattern only has 16 bits
		wid = (int'(r.width) > SPR_W_MAX) ? SPR_W_MAX : int'(r.width);
		if (int'(r.row) < SPR_ROWS && line >= 0 && line < SCR_H) begin
			for (int j = 0; j < wid; j++) begin
				bit_no = r.mirror ? j : wid - 1 - j;
				col = sx_i + j;
				if (bit_no < BITS_W && r.bits[bit_no] && col >= 0 && col < SCR_W) begin
					// address wraps at 32 bits
					w.addr  = base_shadow + (32'(line) << LINE_SHIFT) + (32'(col) << 1);
					w.color = r.color;
					w.last  = 1'b0;
					hits.push_back(w);
				end
			end
		end
		if (hits.size() == 0)
			rows_blank++;
		else
			hits[hits.size() - 1].last = 1'b1;
		foreach (hits[k])
			writes_due.push_back(hits[k]);
	endtask

	// monitor: checks write beats, then predicts from the row beat of the same edge
	always @(posedge clk) begin
		pixel_write_t want;
		row_taken = 1'b0;
		if (arst_n) begin
			if (cfg_we)
				base_shadow = cfg_wdata;

			if (pix_ch.valid && pix_ch.ready) begin
				writes_seen++;
				if (writes_due.size() == 0) begin
					$display("%0t ns: unexpected write, expected none, got addr %h color %h last %b",
						$time, pix_ch.pixel_address, pix_ch.pixel_color, pix_ch.last_of_row);
					errors++;
				end else begin
					want = writes_due.pop_front();
					if (pix_ch.pixel_address !== want.addr) begin
						$display("%0t ns: pixel_address expected %h got %h",
							$time, want.addr, pix_ch.pixel_address);
						errors++;
					end
					if (pix_ch.pixel_color !== want.color) begin
						$display("%0t ns: pixel_color expected %h got %h",
							$time, want.color, pix_ch.pixel_color);
						errors++;
					end
					if (pix_ch.last_of_row !== want.last) begin
						$display("%0t ns: last_of_row expected %b got %b",
							$time, want.last, pix_ch.last_of_row);
						errors++;
					end
				end
			end

			if (row_ch.valid && row_ch.ready) begin
				row_taken = 1'b1;
				rows_sent++;
				expand_row('{row_ch.sprite_x, row_ch.sprite_y, row_ch.row_index,
					row_ch.row_bits, row_ch.row_width, row_ch.mirror, row_ch.color});
			end
		end
	end

	// row driver: a new beat only once the previous one is taken, random gaps between
	always @(negedge clk) begin
		if (arst_n && (!row_ch.valid || row_taken)) begin
			if (send_gap > 0) begin
				send_gap--;
				row_ch.valid <= 1'b0;
			end else if (!quiet && $urandom_range(0, 5) == 0) begin
				// random gap burst
				send_gap = $urandom_range(0, 3);
				row_ch.valid <= 1'b0;
			end else if (rows_pending.size() > 0) begin
				next_row = rows_pending.pop_front();
				row_ch.sprite_x  <= next_row.sx;
				row_ch.sprite_y  <= next_row.sy;
				row_ch.row_index <= next_row.row;
				row_ch.row_bits  <= next_row.bits;
				row_ch.row_width <= next_row.width;
				row_ch.mirror    <= next_row.mirror;
				row_ch.color     <= next_row.color;
				row_ch.valid     <= 1'b1;
			end else begin
				row_ch.valid <= 1'b0;
			end
		end
	end

	// write receiver: random stall bursts
	always @(negedge clk) begin
		if (arst_n) begin
			if (stall_gap > 0) begin
				stall_gap--;
				pix_ch.ready <= 1'b0;
			end else if (!quiet && $urandom_range(0, 4) == 0) begin
				stall_gap = $urandom_range(0, 3);
				pix_ch.ready <= 1'b0;
			end else begin
				pix_ch.ready <= 1'b1;
			end
		end
	end

	task automatic add_row(input int sx, input int sy, input int row, input int bits,
		input int width, input bit mirror, input int color);
		rows_pending.push_back('{11'(sx), 11'(sy), 4'(row), 16'(bits), 5'(width),
			mirror, 16'(color)});
	endtask

	// mostly sprites near the screen, some rows with every field at random
	task automatic add_random_rows(input int n);
		int wid;
		for (int i = 0; i < n; i++) begin
			if ($urandom_range(0, 4) == 0) begin
				add_row($urandom, $urandom, $urandom, $urandom, $urandom,
					1'($urandom_range(0, 1)), $urandom);
			end else begin
				wid = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 31)
					: $urandom_range(1, SPR_W_MAX);
				add_row(int'($urandom_range(0, SCR_W + 30)) - 20,
					int'($urandom_range(0, SCR_H + 35)) - 20,
					$urandom_range(0, 15), $urandom, wid, 1'($urandom_range(0, 1)),
					$urandom);
			end
		end
	endtask

	// sender holds off until nothing is pending or due, then the block settles
	task automatic wait_drained();
		while (rows_pending.size() != 0 || row_ch.valid || writes_due.size() != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	task automatic write_base(input logic [ADDR_W-1:0] value);
		wait_drained();
		cfg_we    <= 1'b1;
		cfg_wdata <= value;
		@(negedge clk);
		cfg_we <= 1'b0;
		bases_used++;
	endtask

	initial begin
		arst_n           = 1'b0;
		cfg_we           = 1'b0;
		cfg_wdata        = '0;
		row_ch.valid     = 1'b0;
		row_ch.sprite_x  = '0;
		row_ch.sprite_y  = '0;
		row_ch.row_index = '0;
		row_ch.row_bits  = '0;
		row_ch.row_width = '0;
		row_ch.mirror    = 1'b0;
		row_ch.color     = '0;
		pix_ch.ready     = 1'b0;
		base_shadow      = FRAME_BASE_RESET;
		bases_used       = 1;

		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed rows under the reset frame base
		add_row(0, 0, 0, 16'hFFFF, 16, 1'b0, 16'hFFFF);     // full row at origin
		add_row(0, 0, 0, 16'hFFFF, 16, 1'b1, 16'h0000);     // same, mirrored
		add_row(100, 50, 3, 16'h8001, 16, 1'b0, 16'h1234);  // only the end columns
		add_row(100, 50, 3, 16'h8001, 16, 1'b1, 16'h5678);
		add_row(100, 50, 3, 16'h0006, 5, 1'b0, 16'h0F0F);   // asymmetric narrow row
		add_row(100, 50, 3, 16'h0006, 5, 1'b1, 16'hF0F0);
		add_row(10, 10, 0, 16'h0001, 1, 1'b0, 16'hAAAA);    // single column
		add_row(10, 10, 0, 16'hFFFF, 0, 1'b0, 16'h5555);    // zero width, no writes
		add_row(20, 20, 0, 16'hFFFF, 17, 1'b1, 16'h00FF);   // oversized width saturates
		add_row(20, 20, 5, 16'hA5A5, 31, 1'b0, 16'hFF00);
		add_row(30, 30, 7, 16'h0000, 16, 1'b0, 16'h1111);   // empty pattern
		add_row(-1024, -1024, 0, 16'hFFFF, 16, 1'b0, 16'h2222);
		add_row(1023, 1023, 15, 16'hFFFF, 16, 1'b1, 16'h3333);
		add_row(-8, 40, 2, 16'hFFFF, 16, 1'b0, 16'h4444);   // clipped on the left
		add_row(312, 40, 2, 16'hFFFF, 16, 1'b1, 16'h6666);  // clipped on the right
		add_row(304, 60, 0, 16'hFFFF, 16, 1'b0, 16'h7777);  // last column on screen
		add_row(-8, 40, 2, 16'hFF00, 16, 1'b0, 16'h8888);   // set bits all off screen
		add_row(50, -16, 15, 16'hFFFF, 16, 1'b0, 16'h9999); // line just above the top
		add_row(50, -15, 15, 16'hC003, 16, 1'b0, 16'hBBBB); // top line
		add_row(50, 224, 15, 16'h3FFC, 16, 1'b1, 16'hCCCC); // bottom line
		add_row(50, 225, 15, 16'hFFFF, 16, 1'b0, 16'hDDDD); // line just below the bottom

		write_base('0);
		add_random_rows(100);
		write_base('1); // addresses wrap past the top
		add_random_rows(80);
		write_base($urandom);
		add_random_rows(80);

		// closing phase, both sides at full rate
		write_base(32'hFFF8_0000);
		quiet = 1'b1;
		add_random_rows(60);

		wait_drained();
		$display("%0d rows sent (%0d with nothing on screen), %0d pixel writes checked",
			rows_sent, rows_blank, writes_seen);
		$display("%0d frame base settings, extremes and wrap included", bases_used);
		if (errors == 0) begin
			$display("mono_sprite_row_blitter_test passed");
		end else begin
			$display("%0d mismatches", errors);
			$display("mono_sprite_row_blitter_test failed");
		end
		$finish;
	end

endmodule

/* filelist.f */
hdl/msrb_pkg.sv
hdl/msrb_if.sv
hdl/msrb_col_scan.sv
hdl/mono_sprite_row_blitter.sv
bench/mono_sprite_row_blitter_test.sv
